// ===== rtl/core/cpu8_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu8_pkg
// Types and constants shared by the 8-bit datapath core, its channel
// interfaces and its checker.
// ----------------------------------------------------------------------------
package cpu8_pkg;

  localparam int unsigned NumRegs    = 4;
  localparam int unsigned RegIdxW    = 2;
  localparam int unsigned DataW      = 8;
  localparam int unsigned AddrW      = 8;
  localparam int unsigned StoreDepth = 256;
  localparam int unsigned InstrW     = 16;

  typedef logic [DataW-1:0]   byte_t;
  typedef logic [RegIdxW-1:0] ridx_t;
  typedef logic [AddrW-1:0]   addr_t;
  typedef logic [InstrW-1:0]  instr_t;

  // Instruction opcodes; the remaining codes execute as no-ops.
  typedef enum logic [3:0] {
    OP_ADD  = 4'h0,
    OP_ADDI = 4'h1,
    OP_OR   = 4'h2,
    OP_SUB  = 4'h3,
    OP_BEQ  = 4'h4,
    OP_LW   = 4'h5,
    OP_SW   = 4'h6,
    OP_J    = 4'h7
  } op_e;

  // Transaction kind carried on the input channel.
  typedef enum logic {
    KIND_EXEC    = 1'b0,
    KIND_PRELOAD = 1'b1
  } kind_e;

  // Decoded effect of one transaction, held between accept and result.
  typedef struct packed {
    logic  reg_we;
    ridx_t reg_idx;
    byte_t reg_val;
    logic  is_load;
    logic  mem_we;
    addr_t mem_addr;
    byte_t mem_val;
  } stage_t;

endpackage

// ===== rtl/core/cpu8_if.sv =====
// ----------------------------------------------------------------------------
// cpu8 channel interfaces
// Valid/ready channels for instruction and preload transactions in, and for
// architectural state reports out.
// ----------------------------------------------------------------------------
interface cpu8_in_if
  import cpu8_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   opcode;
  instr_t instruction;
  addr_t  preload_address;
  byte_t  preload_value;

  modport source (output valid, opcode, instruction, preload_address, preload_value,
                  input ready);
  modport sink   (input valid, opcode, instruction, preload_address, preload_value,
                  output ready);
  modport monitor (input valid, ready, opcode, instruction, preload_address,
                   preload_value);
endinterface

interface cpu8_out_if
  import cpu8_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t reg_value_0;
  byte_t reg_value_1;
  byte_t reg_value_2;
  byte_t reg_value_3;
  logic  wrote_register;
  ridx_t written_register;
  byte_t written_value;
  logic  wrote_memory;
  addr_t memory_address;
  byte_t memory_value;

  modport source (output valid, reg_value_0, reg_value_1, reg_value_2, reg_value_3,
                  wrote_register, written_register, written_value,
                  wrote_memory, memory_address, memory_value,
                  input ready);
  modport sink   (input valid, reg_value_0, reg_value_1, reg_value_2, reg_value_3,
                  wrote_register, written_register, written_value,
                  wrote_memory, memory_address, memory_value,
                  output ready);
  modport monitor (input valid, ready, reg_value_0, reg_value_1, reg_value_2,
                   reg_value_3, wrote_register, written_register, written_value,
                   wrote_memory, memory_address, memory_value);
endinterface

// ===== rtl/core/eight_bit_single_cycle_cpu_datapath_core.sv =====
// ----------------------------------------------------------------------------
// eight_bit_single_cycle_cpu_datapath_core
// Executes one 16-bit instruction or one data preload per transaction against
// a four-entry register file and a 256-byte synchronous data memory.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  in_ch_i   in   item kind, instruction word, preload address and byte
//  out_ch_o  out  register file after the item, register and memory writes
//
// One transaction per cycle is sustained while out_ch_o is not stalled. A
// transaction moves from the execute stage to the output register when that
// register is empty or being read, and its result is presented from there.
// Loads read the data memory at accept; the read data is forwarded from the
// execute stage to the next instruction, so there is no load-use bubble.
// Reset clears the register file and the 256 memory valid bits at once; an
// entry never written reads as zero. No clearing pass is needed.
// While out_ch_o is stalled the output register holds its result and one more
// transaction can still be accepted into the execute stage.
module eight_bit_single_cycle_cpu_datapath_core
  import cpu8_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cpu8_in_if.sink    in_ch_i,
  cpu8_out_if.source out_ch_o
);

  // Execute stage.
  logic   s1_valid_q;
  stage_t s1_q;
  logic   s1_adv;

  // Architectural state.
  byte_t              rf_q [NumRegs];
  byte_t              mem_q [StoreDepth];
  logic [StoreDepth-1:0] vld_q;
  byte_t              rdata_q;
  logic               rvld_q;

  // Output register.
  logic   out_valid_q;
  byte_t  out_regs_q [NumRegs];
  stage_t out_q;

  byte_t  rf_view [NumRegs];
  byte_t  s1_val;
  stage_t s1_rep;
  stage_t nxt;
  addr_t  eff;
  logic   accept;
  kind_e  kind;
  op_e    op;
  ridx_t  rs, rt, rd;
  byte_t  imm, opa, opb;

  assign s1_adv = s1_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ch_i.ready = !s1_valid_q || s1_adv;
  assign accept = in_ch_i.valid && in_ch_i.ready;

  // The execute-stage write is merged into the register view, so younger
  // instructions and the result report both see it before it commits.
  assign s1_val = s1_q.is_load ? (rvld_q ? rdata_q : '0) : s1_q.reg_val;

  always_comb begin
    s1_rep         = s1_q;
    s1_rep.reg_val = s1_val;
  end

  always_comb begin
    for (int k = 0; k < NumRegs; k++) begin
      rf_view[k] = (s1_valid_q && s1_q.reg_we && (s1_q.reg_idx == ridx_t'(k)))
                   ? s1_val : rf_q[k];
    end
  end

  // Decode and execute.
  always_comb begin
    kind = kind_e'(in_ch_i.opcode);
    op   = op_e'(in_ch_i.instruction[15:12]);
    rs   = in_ch_i.instruction[11:10];
    rt   = in_ch_i.instruction[9:8];
    rd   = in_ch_i.instruction[7:6];
    imm  = in_ch_i.instruction[7:0];
    opa  = rf_view[rs];
    opb  = rf_view[rt];
    eff  = opa + imm;
    nxt  = '0;
    if (kind == KIND_PRELOAD) begin
      nxt.mem_we   = 1'b1;
      nxt.mem_addr = in_ch_i.preload_address;
      nxt.mem_val  = in_ch_i.preload_value;
    end else begin
      case (op)
        OP_ADD: begin
          nxt.reg_we  = 1'b1;
          nxt.reg_idx = rd;
          nxt.reg_val = opa + opb;
        end
        OP_ADDI: begin
          nxt.reg_we  = 1'b1;
          nxt.reg_idx = rt;
          nxt.reg_val = eff;
        end
        OP_OR: begin
          nxt.reg_we  = 1'b1;
          nxt.reg_idx = rd;
          nxt.reg_val = opa | opb;
        end
        OP_SUB: begin
          nxt.reg_we  = 1'b1;
          nxt.reg_idx = rd;
          nxt.reg_val = opa - opb;
        end
        OP_LW: begin
          nxt.reg_we  = 1'b1;
          nxt.reg_idx = rt;
          nxt.is_load = 1'b1;
        end
        OP_SW: begin
          nxt.mem_we   = 1'b1;
          nxt.mem_addr = eff;
          nxt.mem_val  = opb;
        end
        default: begin
          nxt = '0;
        end
      endcase
    end
  end

  // Data memory: write and registered read both happen at accept.
  always_ff @(posedge clk_i) begin
    if (accept && nxt.mem_we) begin
      mem_q[nxt.mem_addr] <= nxt.mem_val;
    end
    if (accept && nxt.is_load) begin
      rdata_q <= mem_q[eff];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else if (accept) begin
      if (nxt.mem_we) begin
        vld_q[nxt.mem_addr] <= 1'b1;
      end
      if (nxt.is_load) begin
        rvld_q <= vld_q[eff];
      end
    end
  end

  // Execute stage control and payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= nxt;
    end
  end

  // Register file commits when the execute stage moves to the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumRegs; k++) begin
        rf_q[k] <= '0;
      end
    end else if (s1_adv) begin
      for (int k = 0; k < NumRegs; k++) begin
        rf_q[k] <= rf_view[k];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      for (int k = 0; k < NumRegs; k++) begin
        out_regs_q[k] <= rf_view[k];
      end
      out_q <= s1_rep;
    end
  end

  assign out_ch_o.valid            = out_valid_q;
  assign out_ch_o.reg_value_0      = out_regs_q[0];
  assign out_ch_o.reg_value_1      = out_regs_q[1];
  assign out_ch_o.reg_value_2      = out_regs_q[2];
  assign out_ch_o.reg_value_3      = out_regs_q[3];
  assign out_ch_o.wrote_register   = out_q.reg_we;
  assign out_ch_o.written_register = out_q.reg_idx;
  assign out_ch_o.written_value    = out_q.reg_val;
  assign out_ch_o.wrote_memory     = out_q.mem_we;
  assign out_ch_o.memory_address   = out_q.mem_addr;
  assign out_ch_o.memory_value     = out_q.mem_val;

endmodule

// ===== rtl/core/cpu8_checker.sv =====
// ----------------------------------------------------------------------------
// cpu8_checker
// Port-level checks on the result channel of the 8-bit datapath core.
// ----------------------------------------------------------------------------
module cpu8_checker
  import cpu8_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input byte_t reg_value_0_i,
  input byte_t reg_value_1_i,
  input byte_t reg_value_2_i,
  input byte_t reg_value_3_i,
  input logic  wrote_register_i,
  input ridx_t written_register_i,
  input byte_t written_value_i,
  input logic  wrote_memory_i,
  input addr_t memory_address_i,
  input byte_t memory_value_i
);

  // A stalled result stays valid and keeps its written value and register 0 value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable(written_value_i) && $stable(reg_value_0_i))
    else $error("result changed while stalled");

  // The reported register file must already contain the reported write.
  a_write_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && wrote_register_i |->
      ((written_register_i != 2'd0) || (reg_value_0_i == written_value_i)) &&
      ((written_register_i != 2'd1) || (reg_value_1_i == written_value_i)) &&
      ((written_register_i != 2'd2) || (reg_value_2_i == written_value_i)) &&
      ((written_register_i != 2'd3) || (reg_value_3_i == written_value_i)))
    else $error("written register not reflected in register values");

  a_no_reg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !wrote_register_i |->
      written_register_i == '0 && written_value_i == '0)
    else $error("register write fields not zero without a write");

  a_no_mem_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !wrote_memory_i |->
      memory_address_i == '0 && memory_value_i == '0)
    else $error("memory write fields not zero without a write");

  // No transaction writes both a register and the data memory.
  a_one_write_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(wrote_register_i && wrote_memory_i))
    else $error("result reports both a register and a memory write");

endmodule

bind eight_bit_single_cycle_cpu_datapath_core cpu8_checker u_cpu8_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_ch_o.valid),
  .out_ready_i        (out_ch_o.ready),
  .reg_value_0_i      (out_ch_o.reg_value_0),
  .reg_value_1_i      (out_ch_o.reg_value_1),
  .reg_value_2_i      (out_ch_o.reg_value_2),
  .reg_value_3_i      (out_ch_o.reg_value_3),
  .wrote_register_i   (out_ch_o.wrote_register),
  .written_register_i (out_ch_o.written_register),
  .written_value_i    (out_ch_o.written_value),
  .wrote_memory_i     (out_ch_o.wrote_memory),
  .memory_address_i   (out_ch_o.memory_address),
  .memory_value_i     (out_ch_o.memory_value)
);

// ===== verif/tb_eight_bit_single_cycle_cpu_datapath_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_eight_bit_single_cycle_cpu_datapath_core
// Self-checking bench for the 8-bit datapath core. A state-tracking checker
// mirrors the register file and data store, predicts the report for every
// accepted transaction and compares it with the core's output in order.
// Directed corner cases come first, then random instruction streams with
// bursty input traffic, random output stalls, one long output hold-off and
// one full drain.
// ----------------------------------------------------------------------------
module tb_eight_bit_single_cycle_cpu_datapath_core;
  import cpu8_pkg::*;

  localparam int unsigned RandomItems   = 1050;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned SettleCycles  = 10;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned MaxReported   = 10;
  localparam logic [3:0]  FirstUnusedOp = 4'h8;
  localparam logic [3:0]  LastUnusedOp  = 4'hF;

  typedef struct packed {
    byte_t reg_0;
    byte_t reg_1;
    byte_t reg_2;
    byte_t reg_3;
    logic  wrote_reg;
    ridx_t reg_idx;
    byte_t reg_val;
    logic  wrote_mem;
    addr_t mem_addr;
    byte_t mem_val;
  } report_t;

  // Mirrors the architectural state and keeps the reports still owed by the core.
  class cpu8_state_checker;
    byte_t       regs[NumRegs];
    byte_t       mem[StoreDepth];
    report_t     expected_q[$];
    int unsigned n_exec, n_unused, n_preload, n_reg_writes, n_stores;
    int unsigned n_checked, n_errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
    endfunction

    function string show(report_t r);
      return $sformatf("regs %h %h %h %h reg_wr %b r%0d=%h mem_wr %b [%h]=%h",
                       r.reg_0, r.reg_1, r.reg_2, r.reg_3, r.wrote_reg, r.reg_idx,
                       r.reg_val, r.wrote_mem, r.mem_addr, r.mem_val);
    endfunction

    function void note_accepted(kind_e kind, instr_t word, addr_t paddr, byte_t pval);
      report_t    r;
      logic [3:0] op;
      ridx_t      rs, rt, rd;
      byte_t      imm, a, b, ea;
      r = '0;
      if (kind == KIND_PRELOAD) begin
        r.wrote_mem = 1'b1;
        r.mem_addr  = paddr;
        r.mem_val   = pval;
        n_preload++;
      end else begin
        op  = word[15:12];
        rs  = word[11:10];
        rt  = word[9:8];
        rd  = word[7:6];
        imm = word[7:0];
        a   = regs[rs];
        b   = regs[rt];
        ea  = a + imm;
        n_exec++;
        if (op >= FirstUnusedOp) n_unused++;
        case (op)
          OP_ADD: begin
            r.wrote_reg = 1'b1; r.reg_idx = rd; r.reg_val = a + b;
          end
          OP_ADDI: begin
            r.wrote_reg = 1'b1; r.reg_idx = rt; r.reg_val = ea;
          end
          OP_OR: begin
            r.wrote_reg = 1'b1; r.reg_idx = rd; r.reg_val = a | b;
          end
          OP_SUB: begin
            r.wrote_reg = 1'b1; r.reg_idx = rd; r.reg_val = a - b;
          end
          OP_LW: begin
            r.wrote_reg = 1'b1; r.reg_idx = rt; r.reg_val = mem[ea];
          end
          OP_SW: begin
            r.wrote_mem = 1'b1; r.mem_addr = ea; r.mem_val = b;
            n_stores++;
          end
          default: ;
        endcase
      end
      if (r.wrote_reg) begin
        regs[r.reg_idx] = r.reg_val;
        n_reg_writes++;
      end
      if (r.wrote_mem) mem[r.mem_addr] = r.mem_val;
      r.reg_0 = regs[0];
      r.reg_1 = regs[1];
      r.reg_2 = regs[2];
      r.reg_3 = regs[3];
      expected_q.push_back(r);
    endfunction

    function void check_report(report_t got);
      report_t exp;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReported)
          $display("ERROR: report with nothing expected: %s", show(got));
        return;
      end
      exp = expected_q.pop_front();
      n_checked++;
      if (got !== exp) begin
        n_errors++;
        if (n_errors <= MaxReported) begin
          $display("ERROR: report %0d mismatch", n_checked);
          $display("  expected %s", show(exp));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   hold_req;
  int unsigned items_sent;
  int unsigned cycle_count;
  cpu8_state_checker chk;

  cpu8_in_if  in_ch ();
  cpu8_out_if out_ch ();

  eight_bit_single_cycle_cpu_datapath_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial chk = new();

  // Watch both channels; every accepted transaction is noted or checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        chk.note_accepted(kind_e'(in_ch.opcode), in_ch.instruction,
                          in_ch.preload_address, in_ch.preload_value);
      if (out_ch.valid && out_ch.ready)
        chk.check_report('{out_ch.reg_value_0, out_ch.reg_value_1,
                           out_ch.reg_value_2, out_ch.reg_value_3,
                           out_ch.wrote_register, out_ch.written_register,
                           out_ch.written_value, out_ch.wrote_memory,
                           out_ch.memory_address, out_ch.memory_value});
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d reports outstanding",
               cycle_count, chk.expected_q.size());
      $display("** eight_bit_single_cycle_cpu_datapath_core: FAILED **");
      $finish;
    end
  end

  // Output side: a random stall mode is chosen for each run of random length; a hold request
  // keeps ready low for a long stretch so the core backs up into its input.
  initial begin
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    hold_left = 0;
    mode_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
      end else if (hold_req) begin
        hold_left = LongHold;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(3);
          mode_left = $urandom_range(96, 16);
        end
        mode_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(1));
          2: out_ch.ready <= (mode_left % 4) != 0;
          default: out_ch.ready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  function automatic instr_t enc(logic [3:0] op, ridx_t rs, ridx_t rt, byte_t imm);
    return {op, rs, rt, imm};
  endfunction

  // Offers one transaction and returns at the edge where it is accepted.
  task automatic offer(kind_e kind, instr_t word, addr_t paddr, byte_t pval);
    in_ch.valid           <= 1'b1;
    in_ch.opcode          <= kind;
    in_ch.instruction     <= word;
    in_ch.preload_address <= paddr;
    in_ch.preload_value   <= pval;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic exec(instr_t word);
    offer(KIND_EXEC, word, 8'($urandom), 8'($urandom));
  endtask

  task automatic preload(addr_t paddr, byte_t pval);
    offer(KIND_PRELOAD, 16'($urandom), paddr, pval);
  endtask

  task automatic idle_for(int unsigned n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (chk.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned sel;
    ridx_t       rs;
    byte_t       imm;
    sel = $urandom_range(99);
    if (sel < 15) begin
      // Half the preloads land in a small window that loads hit often.
      if ($urandom_range(1) != 0) preload(8'($urandom), 8'($urandom));
      else preload(8'($urandom_range(15)), 8'($urandom));
    end else if (sel < 23) begin
      exec({4'($urandom_range(LastUnusedOp, FirstUnusedOp)), 12'($urandom)});
    end else if (sel < 31) begin
      // Store followed by a load of the same address.
      rs  = 2'($urandom);
      imm = 8'($urandom);
      exec(enc(OP_SW, rs, 2'($urandom), imm));
      exec(enc(OP_LW, rs, 2'($urandom), imm));
    end else begin
      if ($urandom_range(1) != 0) imm = 8'($urandom);
      else imm = {2'($urandom), 6'($urandom_range(15))};
      exec(enc(4'($urandom_range(7)), 2'($urandom), 2'($urandom), imm));
    end
  endtask

  initial begin
    bit          held;
    bit          paused;
    int unsigned burst;
    held   = 1'b0;
    paused = 1'b0;
    hold_req              = 1'b0;
    items_sent            = 0;
    cycle_count           = 0;
    rst_ni                = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.opcode          = KIND_EXEC;
    in_ch.instruction     = '0;
    in_ch.preload_address = '0;
    in_ch.preload_value   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases. Preloads carry a full instruction word that
    // must be ignored, and executes carry preload fields that must be ignored.
    offer(KIND_PRELOAD, 16'hFFFF, 8'hFF, 8'hFF);
    offer(KIND_PRELOAD, 16'h0000, 8'h00, 8'h5A);
    offer(KIND_PRELOAD, 16'h1234, 8'h80, 8'h01);
    offer(KIND_EXEC, enc(OP_ADDI, 2'd0, 2'd0, 8'hFF), 8'hFF, 8'hFF);
    exec(enc(OP_ADDI, 2'd0, 2'd1, 8'h02));
    exec(enc(OP_ADD, 2'd0, 2'd1, {2'd2, 6'h3F}));
    exec(enc(OP_SUB, 2'd1, 2'd0, {2'd3, 6'h00}));
    exec(enc(OP_OR, 2'd0, 2'd1, {2'd3, 6'h2A}));
    exec(enc(OP_SUB, 2'd2, 2'd2, {2'd2, 6'h15}));
    exec(enc(OP_LW, 2'd0, 2'd2, 8'h00));
    exec(enc(OP_LW, 2'd1, 2'd3, 8'hFF));
    exec(enc(OP_SW, 2'd0, 2'd3, 8'h81));
    exec(enc(OP_LW, 2'd2, 2'd1, 8'h81));
    // A load whose destination is used by the very next instruction.
    exec(enc(OP_LW, 2'd3, 2'd0, 8'h00));
    exec(enc(OP_ADD, 2'd0, 2'd0, {2'd0, 6'h3F}));
    exec(enc(OP_BEQ, 2'd1, 2'd2, 8'hC5));
    exec(enc(OP_J, 2'd3, 2'd3, 8'hFF));
    exec({FirstUnusedOp, 12'hABC});
    exec(16'hFFFF);
    exec(16'h0000);
    exec(enc(OP_SW, 2'd1, 2'd0, 8'hFE));
    preload(8'hFF, 8'h00);
    exec(enc(OP_LW, 2'd1, 2'd2, 8'hFE));
    wait_drained();

    while (items_sent < RandomItems) begin
      burst = $urandom_range(24, 1);
      repeat (burst) random_item();
      if (!held && items_sent >= 300) begin
        // Keep offering back to back while the output side is held off.
        held     = 1'b1;
        hold_req = 1'b1;
        repeat (40) random_item();
      end
      if (!paused && items_sent >= 650) begin
        paused = 1'b1;
        wait_drained();
      end
      if ($urandom_range(2) != 0) idle_for($urandom_range(6, 1));
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Covered %0d instructions (%0d with unused opcodes) and %0d preloads;",
             chk.n_exec, chk.n_unused, chk.n_preload);
    $display("%0d reports checked, %0d register writes, %0d stores, %0d mismatches.",
             chk.n_checked, chk.n_reg_writes, chk.n_stores, chk.n_errors);
    if (chk.n_errors == 0 && chk.expected_q.size() == 0)
      $display("** eight_bit_single_cycle_cpu_datapath_core: PASSED **");
    else
      $display("** eight_bit_single_cycle_cpu_datapath_core: FAILED **");
    $finish;
  end

endmodule

// ===== eight_bit_single_cycle_cpu_datapath_core.f =====
rtl/core/cpu8_pkg.sv
rtl/core/cpu8_if.sv
rtl/core/eight_bit_single_cycle_cpu_datapath_core.sv
rtl/core/cpu8_checker.sv
verif/tb_eight_bit_single_cycle_cpu_datapath_core.sv
